// ===== rtl/core/tof_pkg.sv =====
// Shared constants for the telnet option filter.
`timescale 1ns / 1ps

package tof_pkg;

  localparam int unsigned BYTE_W = 8;

  typedef logic [BYTE_W-1:0] byte_t;

  // Telnet command codes
  localparam byte_t CMD_WILL = 8'hfb;
  localparam byte_t CMD_WONT = 8'hfc;
  localparam byte_t CMD_DO   = 8'hfd;
  localparam byte_t CMD_DONT = 8'hfe;
  localparam byte_t CMD_IAC  = 8'hff;

  localparam byte_t ACCEPTED_OPTION_RESET = 8'h03;

  // Beats left in the output stage: 0, 1 (data or option), 2 (verb), 3 (IAC)
  localparam int unsigned REPLY_LEN = 3;
  localparam int unsigned BEAT_CNT_W = $clog2(REPLY_LEN + 1);

  typedef logic [BEAT_CNT_W-1:0] beat_cnt_t;

  localparam beat_cnt_t BEATS_NONE  = BEAT_CNT_W'(0);
  localparam beat_cnt_t BEATS_ONE   = BEAT_CNT_W'(1);
  localparam beat_cnt_t BEATS_VERB  = BEAT_CNT_W'(2);
  localparam beat_cnt_t BEATS_REPLY = BEAT_CNT_W'(REPLY_LEN);

  localparam logic KIND_DATA  = 1'b0;
  localparam logic KIND_REPLY = 1'b1;

endpackage

// ===== rtl/core/tof_in_if.sv =====
// Input byte channel: valid/ready handshake with one telnet byte per beat.
`timescale 1ns / 1ps

interface tof_in_if;
  logic            valid;
  logic            ready;
  tof_pkg::byte_t  data_byte;
  logic            chunk_end;

  modport source (output valid, output data_byte, output chunk_end, input ready);
  modport sink   (input valid, input data_byte, input chunk_end, output ready);
endinterface

// ===== rtl/core/tof_out_if.sv =====
// Result channel: valid/ready handshake with one data or reply byte per beat.
`timescale 1ns / 1ps

interface tof_out_if;
  logic            valid;
  logic            ready;
  logic            kind;
  tof_pkg::byte_t  value;
  logic            last;

  modport source (output valid, output kind, output value, output last, input ready);
  modport sink   (input valid, input kind, input value, input last, output ready);
endinterface

// ===== rtl/core/telnet_option_filter_core.sv =====
// Top level of the telnet option filter: byte parser and reply output stage.
`timescale 1ns / 1ps

//  channel | dir | payload                          | handshake
//  --------+-----+----------------------------------+-------------------------
//  rx      | in  | data_byte[7:0], chunk_end        | valid/ready
//  tx      | out | kind, value[7:0], last           | valid/ready
//  cfg     | in  | cfg_wr_data[7:0] (accepted_option)| cfg_wr_en, no back-pressure
//
//  One input beat is taken per cycle while rx is ready. A data byte below 8'h80
//  leaves as one result beat, a negotiation reply as three; rx holds off only
//  while the last of those beats is not yet leaving.
//  The output register holds the pending beats; while tx stalls they hold.
//  rst is synchronous: parser back to plain data, output stage empty,
//  accepted_option back to 3 (suppress go ahead).

module telnet_option_filter_core (
  input  logic              clk,
  input  logic              rst,
  tof_in_if.sink            rx,
  tof_out_if.source         tx,
  input  logic              cfg_wr_en,
  input  tof_pkg::byte_t    cfg_wr_data
);

  // Parser phases
  localparam logic [1:0] PH_DATA = 2'd0;  // plain data
  localparam logic [1:0] PH_IAC  = 2'd1;  // IAC seen, next byte is the command
  localparam logic [1:0] PH_OPT  = 2'd2;  // command held, next byte is its option

  tof_pkg::byte_t     accepted_option;

  logic [1:0]         parse_phase;
  logic [1:0]         parse_phase_next;
  tof_pkg::byte_t     held_command;
  tof_pkg::byte_t     held_command_next;

  // Output stage: beats left, and the bytes they are built from
  tof_pkg::beat_cnt_t beat_cnt;
  tof_pkg::beat_cnt_t beat_cnt_next;
  logic               out_kind;
  logic               out_kind_next;
  tof_pkg::byte_t     out_verb;
  tof_pkg::byte_t     out_verb_next;
  tof_pkg::byte_t     out_byte;
  tof_pkg::byte_t     out_byte_next;

  logic               rx_fire;
  logic               tx_fire;
  logic               opt_ok;

  assign tx_fire = tx.valid && tx.ready;
  assign rx_fire = rx.valid && rx.ready;

  // Accept when the output stage is empty or its final beat leaves this cycle
  assign rx.ready = (beat_cnt == tof_pkg::BEATS_NONE) ||
                    ((beat_cnt == tof_pkg::BEATS_ONE) && tx.ready);

  // Present IAC, then the verb, then the option (or the data byte)
  assign tx.valid = (beat_cnt != tof_pkg::BEATS_NONE);
  assign tx.kind  = out_kind;
  assign tx.last  = (beat_cnt == tof_pkg::BEATS_ONE);
  always_comb begin
    case (beat_cnt)
      tof_pkg::BEATS_REPLY: tx.value = tof_pkg::CMD_IAC;
      tof_pkg::BEATS_VERB:  tx.value = out_verb;
      default:              tx.value = out_byte;
    endcase
  end

  assign opt_ok = (rx.data_byte == accepted_option);

  always_comb begin
    parse_phase_next  = parse_phase;
    held_command_next = held_command;
    out_kind_next     = out_kind;
    out_verb_next     = out_verb;
    out_byte_next     = out_byte;
    beat_cnt_next     = beat_cnt;

    // Retire one beat per tx handshake
    if (tx_fire) begin
      beat_cnt_next = beat_cnt - tof_pkg::BEATS_ONE;
    end

    if (rx_fire) begin
      // Stage is empty or draining its last beat: a new load replaces it
      beat_cnt_next = tof_pkg::BEATS_NONE;
      out_byte_next = rx.data_byte;

      unique case (parse_phase)
        PH_IAC: begin
          // IAC IAC is dropped whole
          if (rx.data_byte == tof_pkg::CMD_IAC) begin
            parse_phase_next = PH_DATA;
          end else begin
            held_command_next = rx.data_byte;
            parse_phase_next  = PH_OPT;
          end
        end
        PH_OPT: begin
          parse_phase_next = PH_DATA;
          out_kind_next    = tof_pkg::KIND_REPLY;
          beat_cnt_next    = tof_pkg::BEATS_REPLY;
          case (held_command)
            tof_pkg::CMD_WILL: out_verb_next = opt_ok ? tof_pkg::CMD_DO : tof_pkg::CMD_DONT;
            tof_pkg::CMD_DO:   out_verb_next = opt_ok ? tof_pkg::CMD_WILL : tof_pkg::CMD_WONT;
            tof_pkg::CMD_WONT: out_verb_next = tof_pkg::CMD_DONT;
            tof_pkg::CMD_DONT: out_verb_next = tof_pkg::CMD_WONT;
            default: begin
              // Other commands: swallow the option byte silently
              beat_cnt_next = tof_pkg::BEATS_NONE;
            end
          endcase
        end
        default: begin
          // Plain data; the unused phase code behaves the same
          if (rx.data_byte == tof_pkg::CMD_IAC) begin
            parse_phase_next = PH_IAC;
          end else begin
            parse_phase_next = PH_DATA;
            if (!rx.data_byte[tof_pkg::BYTE_W-1]) begin
              out_kind_next = tof_pkg::KIND_DATA;
              beat_cnt_next = tof_pkg::BEATS_ONE;
            end
          end
        end
      endcase

      // Chunk end abandons any partial command
      if (rx.chunk_end) begin
        parse_phase_next = PH_DATA;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      parse_phase     <= PH_DATA;
      held_command    <= '0;
      beat_cnt        <= tof_pkg::BEATS_NONE;
      accepted_option <= tof_pkg::ACCEPTED_OPTION_RESET;
    end else begin
      parse_phase  <= parse_phase_next;
      held_command <= held_command_next;
      beat_cnt     <= beat_cnt_next;
      if (cfg_wr_en) begin
        accepted_option <= cfg_wr_data;
      end
    end
  end

  // Payload: no reset needed
  always_ff @(posedge clk) begin
    out_kind <= out_kind_next;
    out_verb <= out_verb_next;
    out_byte <= out_byte_next;
  end

endmodule

// ===== rtl/core/tof_checker.sv =====
// Port-level checks for the telnet option filter, bound to its top level.
`timescale 1ns / 1ps

module tof_checker (
  input logic            clk,
  input logic            rst,
  input logic            rx_ready,
  input logic            tx_valid,
  input logic            tx_ready,
  input logic            tx_kind,
  input tof_pkg::byte_t  tx_value,
  input logic            tx_last
);

  // A stalled beat holds its value
  a_tx_hold: assert property (@(posedge clk) disable iff (rst)
    tx_valid && !tx_ready |=> tx_valid && $stable(tx_value))
    else $error("tx beat changed while stalled");

  // The rest of a reply follows at once
  a_reply_burst: assert property (@(posedge clk) disable iff (rst)
    tx_valid && tx_ready && !tx_last |=> tx_valid && tx_kind)
    else $error("reply beats not contiguous");

  // Only reply beats can be non-final, and data beats have bit 7 clear
  a_data_single: assert property (@(posedge clk) disable iff (rst)
    tx_valid && !tx_kind |-> tx_last && !tx_value[7])
    else $error("bad data beat");

  // Input is held off only while results are pending
  a_ready_cause: assert property (@(posedge clk) disable iff (rst)
    !rx_ready |-> tx_valid)
    else $error("rx stalled with empty output stage");

endmodule

bind telnet_option_filter_core tof_checker u_tof_checker (
  .clk      (clk),
  .rst      (rst),
  .rx_ready (rx.ready),
  .tx_valid (tx.valid),
  .tx_ready (tx.ready),
  .tx_kind  (tx.kind),
  .tx_value (tx.value),
  .tx_last  (tx.last)
);
